// ===== src/ctss_pkg.sv =====
// shared types, constants and codes of the closest track segment search
package ctss_pkg;

  // fixed field widths
  localparam int IW          = 11;
  localparam int CNT_W       = 11;
  localparam int COORD_W     = 32;
  localparam int TIME_W      = 31;
  localparam int FRAC_W      = 16;
  localparam int THR_W       = 32;
  localparam int DIST_W      = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 208;
  localparam int WIN_W       = 27;

  // default store depth
  localparam int MAX_POINTS_DEF = 1024;

  // start index reduction runs one dividend bit per cycle
  localparam int DIV_STEPS = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_FRACTION = 2'd2;

  // register reset values
  localparam logic [CNT_W-1:0]  POINT_COUNT_RST     = 11'd0;
  localparam logic [THR_W-1:0]  CLOSE_THRESHOLD_RST = 32'd351844;
  localparam logic [FRAC_W-1:0] WINDOW_FRACTION_RST = 16'd16384;

  // item kinds
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // index reported when nothing qualifies
  localparam logic [IW-1:0] NOT_FOUND_IDX = 11'h7FF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [TIME_W-1:0]  tms;
  } point_t;

  typedef struct packed {
    logic [IW-1:0] idx;
    logic          inwin;
  } tag_t;

  typedef struct packed {
    logic vld;
    tag_t tag;
  } issue_t;

  typedef struct packed {
    logic              vld;
    logic [DIST_W-1:0] d;
    point_t            pt;
    tag_t              tag;
  } dres_t;

  typedef struct packed {
    logic               mode;
    logic [IW-1:0]      point_index;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [TIME_W-1:0]  time_ms;
    logic [FRAC_W-1:0]  lap_fraction;
  } item_t;

endpackage

// ===== src/ctss_store.sv =====
// reference point store: one write port, one registered read port
module ctss_store #(
  parameter int MAX_POINTS = ctss_pkg::MAX_POINTS_DEF,
  parameter int AW         = $clog2(ctss_pkg::MAX_POINTS_DEF)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  ctss_pkg::point_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output ctss_pkg::point_t rdata
);
  import ctss_pkg::*;

  point_t mem [MAX_POINTS];
  point_t rdata_r;

  // write on load, read registered in the cycle before use
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ctss_dist.sv =====
// squared distance pipeline from stored point to query position
module ctss_dist (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      flush,
  input  ctss_pkg::issue_t          iss,
  input  ctss_pkg::point_t          rd_data,
  input  logic [ctss_pkg::COORD_W-1:0] qx,
  input  logic [ctss_pkg::COORD_W-1:0] qy,
  output ctss_pkg::dres_t           dres
);
  import ctss_pkg::*;

  logic                s1_vld_r;
  tag_t                s1_tag_r;
  logic                s2_vld_r;
  tag_t                s2_tag_r;
  point_t              s2_pt_r;
  logic [COORD_W-1:0]  s2_ax_r;
  logic [COORD_W-1:0]  s2_ay_r;
  logic                s3_vld_r;
  tag_t                s3_tag_r;
  point_t              s3_pt_r;
  logic [DIST_W-1:0]   s3_sqx_r;
  logic [DIST_W-1:0]   s3_sqy_r;
  logic                s4_vld_r;
  tag_t                s4_tag_r;
  point_t              s4_pt_r;
  logic [DIST_W-1:0]   s4_d_r;
  logic [COORD_W:0]    dx;
  logic [COORD_W:0]    dy;
  logic [COORD_W-1:0]  ax;
  logic [COORD_W-1:0]  ay;

  // exact 33 bit differences and their magnitudes
  always_comb begin
    dx = {rd_data.x[COORD_W-1], rd_data.x} - {qx[COORD_W-1], qx};
    dy = {rd_data.y[COORD_W-1], rd_data.y} - {qy[COORD_W-1], qy};
    ax = dx[COORD_W] ? COORD_W'((COORD_W+1)'(0) - dx) : dx[COORD_W-1:0];
    ay = dy[COORD_W] ? COORD_W'((COORD_W+1)'(0) - dy) : dy[COORD_W-1:0];
  end

  // stage valids, cleared when a walk ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= !flush && iss.vld;
      s2_vld_r <= !flush && s1_vld_r;
      s3_vld_r <= !flush && s2_vld_r;
      s4_vld_r <= !flush && s3_vld_r;
    end
  end

  // payload: align tag with read data, abs diff, square, sum
  always_ff @(posedge clk) begin
    s1_tag_r <= iss.tag;
    s2_tag_r <= s1_tag_r;
    s2_pt_r  <= rd_data;
    s2_ax_r  <= ax;
    s2_ay_r  <= ay;
    s3_tag_r <= s2_tag_r;
    s3_pt_r  <= s2_pt_r;
    s3_sqx_r <= s2_ax_r * s2_ax_r;
    s3_sqy_r <= s2_ay_r * s2_ay_r;
    s4_tag_r <= s3_tag_r;
    s4_pt_r  <= s3_pt_r;
    s4_d_r   <= s3_sqx_r + s3_sqy_r;
  end

  assign dres.vld = s4_vld_r;
  assign dres.d   = s4_d_r;
  assign dres.pt  = s4_pt_r;
  assign dres.tag = s4_tag_r;

endmodule

// ===== src/ctss_seq.sv =====
// sequencer: config registers, start reduction, ring walk, best tracking, result register
module ctss_seq #(
  parameter int MAX_POINTS = ctss_pkg::MAX_POINTS_DEF,
  parameter int AW         = $clog2(ctss_pkg::MAX_POINTS_DEF)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ctss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ctss_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  ctss_pkg::item_t                   in_item,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ctss_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tuser,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output ctss_pkg::point_t                  mem_wdata,
  output ctss_pkg::issue_t                  iss,
  output logic [AW-1:0]                     rd_addr,
  output logic [ctss_pkg::COORD_W-1:0]      qx,
  output logic [ctss_pkg::COORD_W-1:0]      qy,
  output logic                              flush,
  input  ctss_pkg::dres_t                   dres
);
  import ctss_pkg::*;

  localparam logic [16:0]        MAXP17   = 17'(MAX_POINTS);
  localparam logic [3:0]         DIV_LAST = 4'(DIV_STEPS - 1);

  state_t                 state_r;
  state_t                 state_nxt;
  logic [CNT_W-1:0]       point_count_r;
  logic [THR_W-1:0]       close_threshold_r;
  logic [FRAC_W-1:0]      window_fraction_r;
  logic [COORD_W-1:0]     px_r;
  logic [COORD_W-1:0]     py_r;
  logic [CNT_W-1:0]       n_r;
  logic [WIN_W-1:0]       fn_r;
  logic [WIN_W-1:0]       wn_r;
  logic [THR_W:0]         thr2_r;
  logic [DIV_STEPS-1:0]   dvd_r;
  logic [CNT_W-1:0]       rem_r;
  logic [3:0]             div_cnt_r;
  logic [IW-1:0]          ix_iss_r;
  logic [CNT_W:0]         iss_cnt_r;
  logic [CNT_W-1:0]       pair_cnt_r;
  logic                   have_prev_r;
  logic [DIST_W-1:0]      dprev_r;
  point_t                 pprev_r;
  tag_t                   tprev_r;
  logic                   found_r;
  logic [DIST_W:0]        best_sum_r;
  logic [IW-1:0]          best_idx_r;
  point_t                 best_first_r;
  point_t                 best_second_r;
  logic                   out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_user_r;
  logic                   accept;
  logic [CNT_W-1:0]       n_in;
  logic                   load_ok;
  logic [CNT_W:0]         div_t;
  logic [CNT_W-1:0]       rem_nxt;
  logic [WIN_W:0]         win_diff;
  logic [WIN_W:0]         win_mag;
  logic [DIST_W:0]        pair_sum;
  logic                   step;
  logic                   take;
  logic                   found_upd;
  logic                   finish;
  logic                   out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r     <= POINT_COUNT_RST;
      close_threshold_r <= CLOSE_THRESHOLD_RST;
      window_fraction_r <= WINDOW_FRACTION_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POINT_COUNT:     point_count_r     <= cfg_wdata[CNT_W-1:0];
        CFG_CLOSE_THRESHOLD: close_threshold_r <= cfg_wdata[THR_W-1:0];
        CFG_WINDOW_FRACTION: window_fraction_r <= cfg_wdata[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // item acceptance and load write
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign n_in      = ({6'd0, point_count_r} > MAXP17) ? MAXP17[CNT_W-1:0] : point_count_r;
  assign load_ok   = !in_item.point_index[IW-1] &&
                     ({6'd0, in_item.point_index} < MAXP17);
  assign mem_we    = accept && (in_item.mode == MODE_LOAD) && load_ok;
  assign mem_waddr = AW'(in_item.point_index);
  assign mem_wdata = '{x: in_item.pos_x, y: in_item.pos_y, tms: in_item.time_ms};

  // one restoring step of start index mod n
  always_comb begin
    div_t   = {rem_r, dvd_r[DIV_STEPS-1]};
    rem_nxt = (div_t >= {1'b0, n_r}) ? CNT_W'(div_t - {1'b0, n_r}) : div_t[CNT_W-1:0];
  end

  // window test for the issued index: |ix*65536 - frac*n| < w*n
  always_comb begin
    win_diff = {1'b0, ix_iss_r, 16'd0} - {1'b0, fn_r};
    win_mag  = win_diff[WIN_W] ? ((WIN_W+1)'(0) - win_diff) : win_diff;
  end

  assign iss.vld       = (state_r == ST_RUN) && (iss_cnt_r <= {1'b0, n_r});
  assign iss.tag.idx   = ix_iss_r;
  assign iss.tag.inwin = win_mag[WIN_W-1:0] < wn_r;
  assign rd_addr       = AW'(ix_iss_r);
  assign qx            = px_r;
  assign qy            = py_r;

  // pair evaluation: segment sum, best update, early stop
  always_comb begin
    pair_sum  = {1'b0, dprev_r} + {1'b0, dres.d};
    step      = (state_r == ST_RUN) && dres.vld && have_prev_r;
    take      = step && tprev_r.inwin && (!found_r || (pair_sum < best_sum_r));
    found_upd = found_r || take;
    finish    = step && ((found_upd && (pair_sum < {32'd0, thr2_r})) ||
                         (pair_cnt_r == n_r - 11'd1));
  end

  assign out_free = !out_vld_r || out_tready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    flush     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.mode == MODE_LOAD || n_in < 11'd2) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_nxt = ST_RESP;
          flush     = 1'b1;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // walk control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r   <= '0;
      iss_cnt_r   <= '0;
      pair_cnt_r  <= '0;
      have_prev_r <= 1'b0;
      found_r     <= 1'b0;
    end else if (accept) begin
      div_cnt_r   <= '0;
      iss_cnt_r   <= '0;
      pair_cnt_r  <= '0;
      have_prev_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      if (state_r == ST_DIV) begin
        div_cnt_r <= div_cnt_r + 4'd1;
      end
      if (iss.vld) begin
        iss_cnt_r <= iss_cnt_r + 12'd1;
      end
      if (state_r == ST_RUN && dres.vld) begin
        have_prev_r <= 1'b1;
      end
      if (step) begin
        pair_cnt_r <= pair_cnt_r + 11'd1;
      end
      if (take) begin
        found_r <= 1'b1;
      end
    end
  end

  // query operands and start index
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r   <= in_item.pos_x;
      py_r   <= in_item.pos_y;
      n_r    <= n_in;
      fn_r   <= WIN_W'(in_item.lap_fraction) * WIN_W'(n_in);
      wn_r   <= WIN_W'(window_fraction_r) * WIN_W'(n_in);
      thr2_r <= {close_threshold_r, 1'b0};
      dvd_r  <= in_item.point_index[IW-1] ? '0 : in_item.point_index[DIV_STEPS-1:0];
      rem_r  <= '0;
    end else if (state_r == ST_DIV) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[DIV_STEPS-2:0], 1'b0};
      if (div_cnt_r == DIV_LAST) begin
        ix_iss_r <= rem_nxt;
      end
    end else if (iss.vld) begin
      ix_iss_r <= (ix_iss_r == n_r - 11'd1) ? '0 : ix_iss_r + 11'd1;
    end
  end

  // previous distance and best segment
  always_ff @(posedge clk) begin
    if (state_r == ST_RUN && dres.vld) begin
      dprev_r <= dres.d;
      pprev_r <= dres.pt;
      tprev_r <= dres.tag;
    end
    if (take) begin
      best_sum_r    <= pair_sum;
      best_idx_r    <= tprev_r.idx;
      best_first_r  <= pprev_r;
      best_second_r <= dres.pt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (state_r == ST_RESP && out_free) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RESP && out_free) begin
      out_user_r <= found_r;
      if (found_r) begin
        out_data_r <= {7'd0,
                       best_second_r.tms, best_second_r.y, best_second_r.x,
                       best_first_r.tms, best_first_r.y, best_first_r.x,
                       best_idx_r};
      end else begin
        out_data_r <= OUT_TDATA_W'(NOT_FOUND_IDX);
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  // issue index stays on the ring
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> ix_iss_r < n_r)
    else $error("issue index beyond point count");

  // walk never evaluates more pairs than points
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> pair_cnt_r < n_r)
    else $error("pair count overran the ring");

  // distances only arrive during a walk
  assert property (@(posedge clk) disable iff (!rst_n)
    dres.vld |-> state_r == ST_RUN)
    else $error("stale distance outside a walk");

  // early stop leaves nothing in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && $past(state_r) == ST_RUN) |-> !dres.vld)
    else $error("pipeline not flushed at walk end");

  // a found result carries a non-negative index
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_user_r) |-> !out_data_r[IW-1])
    else $error("found result with negative index");
`endif

endmodule

// ===== src/closest_track_segment_search_top.sv =====
// top level of the closest track segment search
// load item: accepted, then its result registered from the response state once the output is free;
// no new item is taken until then. query: the start index is reduced, then the ring walk reads
// one stored point per cycle through the single store read port into the distance pipeline and
// result register; a walk ends early on a close segment, and n < 2 goes straight to the result
// reset (synchronous, rst_n low) clears control and restores register defaults; store untouched
module closest_track_segment_search_top #(
  parameter int MAX_POINTS = ctss_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ctss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // point_index[10:0], pos_x[42:11], pos_y[74:43], time_ms[105:75], lap_fraction[121:106]
  input  logic [ctss_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // best_index[10:0], first_x[42:11], first_y[74:43], first_time[105:75],
  // second_x[137:106], second_y[169:138], second_time[200:170]
  output logic [ctss_pkg::OUT_TDATA_W-1:0] out_tdata,
  // found[0]
  output logic                             out_tuser
);
  import ctss_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  item_t              in_item;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  point_t             mem_wdata;
  issue_t             iss;
  logic [AW-1:0]      rd_addr;
  point_t             rd_data;
  logic [COORD_W-1:0] qx;
  logic [COORD_W-1:0] qy;
  logic               flush;
  dres_t              dres;

  // input item fields
  assign in_item.mode         = in_tuser;
  assign in_item.point_index  = in_tdata[10:0];
  assign in_item.pos_x        = in_tdata[42:11];
  assign in_item.pos_y        = in_tdata[74:43];
  assign in_item.time_ms      = in_tdata[105:75];
  assign in_item.lap_fraction = in_tdata[121:106];

  ctss_store #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (iss.vld),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  ctss_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .flush   (flush),
    .iss     (iss),
    .rd_data (rd_data),
    .qx      (qx),
    .qy      (qy),
    .dres    (dres)
  );

  ctss_seq #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .iss        (iss),
    .rd_addr    (rd_addr),
    .qx         (qx),
    .qy         (qy),
    .flush      (flush),
    .dres       (dres)
  );

endmodule

// ===== tb/segment_search_checker.sv =====
`timescale 1ns / 1ps
// checker: watches the channels, predicts each closest segment and compares the results
module segment_search_checker #(
  parameter int MAX_POINTS = ctss_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ctss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // point_index[10:0], pos_x[42:11], pos_y[74:43], time_ms[105:75], lap_fraction[121:106]
  input  logic [ctss_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode[0]
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // best_index[10:0], first_x[42:11], first_y[74:43], first_time[105:75],
  // second_x[137:106], second_y[169:138], second_time[200:170]
  input  logic [ctss_pkg::OUT_TDATA_W-1:0] out_tdata,
  // found[0]
  input  logic                             out_tuser,
  output int                               fail_count,
  output int                               results_due
);
  import ctss_pkg::*;

  typedef struct packed {
    logic          found;
    logic [IW-1:0] best_index;
    point_t        first_pt;
    point_t        second_pt;
  } segment_t;

  // mirrored point store and registers
  logic [COORD_W-1:0] pt_x  [MAX_POINTS];
  logic [COORD_W-1:0] pt_y  [MAX_POINTS];
  logic [TIME_W-1:0]  pt_ms [MAX_POINTS];
  logic [CNT_W-1:0]   point_cnt;
  logic [THR_W-1:0]   close_thr;
  logic [FRAC_W-1:0]  win_frac;

  segment_t pending_segments[$];
  segment_t seg_exp;
  segment_t seg_act;
  int       errs;

  logic              in_mode;
  logic signed [IW-1:0] in_idx;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic [TIME_W-1:0]  in_ms;
  logic [FRAC_W-1:0]  in_frac;

  // squared distance of one stored point to the query position, wraps at 64 bits
  function automatic logic [DIST_W-1:0] point_dist(input int idx, input logic [31:0] qx,
                                                   input logic [31:0] qy);
    logic [32:0] dx;
    logic [32:0] dy;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [63:0] sx;
    logic [63:0] sy;
    dx = {pt_x[idx][31], pt_x[idx]} - {qx[31], qx};
    dy = {pt_y[idx][31], pt_y[idx]} - {qy[31], qy};
    ax = dx[32] ? 32'(-dx) : dx[31:0];
    ay = dy[32] ? 32'(-dy) : dy[31:0];
    sx = 64'(ax) * 64'(ax);
    sy = 64'(ay) * 64'(ay);
    return sx + sy;
  endfunction

  function automatic point_t stored_point(input int idx);
    point_t p;
    p.x   = pt_x[idx];
    p.y   = pt_y[idx];
    p.tms = pt_ms[idx];
    return p;
  endfunction

  // ring walk from the start point, keeping the closest segment inside the lap window
  function automatic segment_t nearest_segment(input logic signed [IW-1:0] start,
                                               input logic [31:0] qx, input logic [31:0] qy,
                                               input logic [FRAC_W-1:0] frac);
    segment_t    r;
    int          n;
    int          ix;
    int          nx;
    int          k;
    int          best;
    logic [63:0] d_cur;
    logic [63:0] d_next;
    logic [64:0] seg_sum;
    logic [64:0] best_sum;
    longint      diff;
    logic        inwin;
    r = '0;
    r.best_index = NOT_FOUND_IDX;
    n = (int'(point_cnt) > MAX_POINTS) ? MAX_POINTS : int'(point_cnt);
    if (n < 2) return r;
    ix = (start < 0) ? 0 : int'(start) % n;
    best = -1;
    best_sum = '0;
    d_next = point_dist(ix, qx, qy);
    for (k = 0; k < n; k++) begin
      nx = (ix + 1) % n;
      d_cur = d_next;
      d_next = point_dist(nx, qx, qy);
      seg_sum = {1'b0, d_cur} + {1'b0, d_next};
      diff = longint'(ix) * 65536 - longint'(frac) * longint'(n);
      if (diff < 0) diff = -diff;
      inwin = diff < longint'(win_frac) * longint'(n);
      if ((best < 0 || seg_sum < best_sum) && inwin) begin
        best_sum = seg_sum;
        best = ix;
      end
      // early stop once a segment is kept and this average is under the threshold
      if (best >= 0 && seg_sum < {32'd0, close_thr, 1'b0}) break;
      ix = nx;
    end
    if (best >= 0) begin
      r.found      = 1'b1;
      r.best_index = IW'(best);
      r.first_pt   = stored_point(best);
      r.second_pt  = stored_point((best + 1) % n);
    end
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errs++;
      $display("%0t: %s expected %0h got %0h", $time, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      point_cnt = POINT_COUNT_RST;
      close_thr = CLOSE_THRESHOLD_RST;
      win_frac  = WINDOW_FRACTION_RST;
      pending_segments.delete();
      errs = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_POINT_COUNT:     point_cnt = cfg_wdata[CNT_W-1:0];
          CFG_CLOSE_THRESHOLD: close_thr = cfg_wdata[THR_W-1:0];
          CFG_WINDOW_FRACTION: win_frac  = cfg_wdata[FRAC_W-1:0];
          default: ;
        endcase
      end

      // accepted input item
      if (in_tvalid && in_tready) begin
        in_mode = in_tuser;
        in_idx  = in_tdata[10:0];
        in_x    = in_tdata[42:11];
        in_y    = in_tdata[74:43];
        in_ms   = in_tdata[105:75];
        in_frac = in_tdata[121:106];
        if (in_mode == MODE_LOAD) begin
          if (in_idx >= 0 && int'(in_idx) < MAX_POINTS) begin
            pt_x[in_idx]  = in_x;
            pt_y[in_idx]  = in_y;
            pt_ms[in_idx] = in_ms;
          end
          seg_exp = '0;
          seg_exp.best_index = NOT_FOUND_IDX;
        end else begin
          seg_exp = nearest_segment(in_idx, in_x, in_y, in_frac);
        end
        pending_segments.push_back(seg_exp);
      end

      // accepted result item
      if (out_tvalid && out_tready) begin
        seg_act.found         = out_tuser;
        seg_act.best_index    = out_tdata[10:0];
        seg_act.first_pt.x    = out_tdata[42:11];
        seg_act.first_pt.y    = out_tdata[74:43];
        seg_act.first_pt.tms  = out_tdata[105:75];
        seg_act.second_pt.x   = out_tdata[137:106];
        seg_act.second_pt.y   = out_tdata[169:138];
        seg_act.second_pt.tms = out_tdata[200:170];
        if (pending_segments.size() == 0) begin
          errs++;
          $display("%0t: result item with nothing expected, found %0b best_index %0h",
                   $time, seg_act.found, seg_act.best_index);
        end else begin
          seg_exp = pending_segments.pop_front();
          check_field("found", 32'(seg_exp.found), 32'(seg_act.found));
          check_field("best_index", 32'(seg_exp.best_index), 32'(seg_act.best_index));
          check_field("first_x", seg_exp.first_pt.x, seg_act.first_pt.x);
          check_field("first_y", seg_exp.first_pt.y, seg_act.first_pt.y);
          check_field("first_time", 32'(seg_exp.first_pt.tms), 32'(seg_act.first_pt.tms));
          check_field("second_x", seg_exp.second_pt.x, seg_act.second_pt.x);
          check_field("second_y", seg_exp.second_pt.y, seg_act.second_pt.y);
          check_field("second_time", 32'(seg_exp.second_pt.tms),
                      32'(seg_act.second_pt.tms));
        end
      end
    end
    fail_count  <= errs;
    results_due <= pending_segments.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// testbench top: clock, reset, stimulus and verdict for the closest track segment search
module tb_top;
  import ctss_pkg::*;

  localparam int STORE_DEPTH  = MAX_POINTS_DEF;
  localparam int RANDOM_ITEMS = 580;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TAIL_CYCLES  = 40;

  typedef enum int {RX_OPEN, RX_COIN, RX_RARE, RX_THIRDS} rx_pattern_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  int                     fail_count;
  int                     results_due;

  // track points as loaded, used to aim queries
  logic [COORD_W-1:0] trk_x [STORE_DEPTH];
  logic [COORD_W-1:0] trk_y [STORE_DEPTH];
  bit                 written [STORE_DEPTH];
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  int                 burst_left;
  int                 cycle_cnt;
  logic               squeeze;

  closest_track_segment_search_top #(.MAX_POINTS(STORE_DEPTH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  segment_search_checker #(.MAX_POINTS(STORE_DEPTH)) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // result side: changing stall patterns, one long hold-off on request
  initial begin
    rx_pattern_t pat;
    int          pat_left;
    int          tick;
    bit          squeezed;
    pat = RX_OPEN;
    pat_left = 0;
    tick = 0;
    squeezed = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze && !squeezed) begin
        squeezed = 1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (pat_left == 0) begin
          pat = rx_pattern_t'($urandom_range(0, 3));
          pat_left = $urandom_range(32, 256);
        end
        pat_left--;
        tick++;
        case (pat)
          RX_OPEN:  out_tready <= 1'b1;
          RX_COIN:  out_tready <= ($urandom_range(0, 1) == 1);
          RX_RARE:  out_tready <= ($urandom_range(0, 7) != 0);
          default:  out_tready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  function automatic logic [31:0] jitter(input logic [31:0] v, input int span);
    return v + 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  // offer one item in bursts with random gaps, return once accepted
  task automatic send_item(input logic mode, input logic [IW-1:0] idx,
                           input logic [31:0] x, input logic [31:0] y,
                           input logic [TIME_W-1:0] t, input logic [FRAC_W-1:0] frac);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {6'd0, frac, t, y, x, idx};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic load_point(input int idx, input logic [31:0] x, input logic [31:0] y,
                            input logic [TIME_W-1:0] t);
    if (idx >= 0) begin
      trk_x[idx] = x;
      trk_y[idx] = y;
      written[idx] = 1;
    end
    send_item(MODE_LOAD, IW'(idx), x, y, t, 16'($urandom));
  endtask

  task automatic query(input int start, input logic [31:0] x, input logic [31:0] y,
                       input logic [FRAC_W-1:0] frac);
    send_item(MODE_QUERY, IW'(start), x, y, TIME_W'($urandom), frac);
  endtask

  // next point along a wandering track, now and then a wild one
  task automatic put_path_point(input int idx);
    logic [31:0] x;
    logic [31:0] y;
    if ($urandom_range(0, 3) == 0) begin
      x = $urandom;
      y = $urandom;
    end else begin
      cur_x = jitter(cur_x, 400);
      cur_y = jitter(cur_y, 400);
      x = cur_x;
      y = cur_y;
    end
    load_point(idx, x, y, TIME_W'($urandom));
  endtask

  // query aimed near a track point, or anywhere
  task automatic random_query(input int n);
    int          j;
    int          start;
    int          sel;
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] frac;
    j = (n < 2) ? 0 : $urandom_range(0, n - 1);
    sel = (n < 2) ? 4 : $urandom_range(0, 4);
    case (sel)
      0, 1: begin
        x = jitter(trk_x[j], 300);
        y = jitter(trk_y[j], 300);
      end
      2: begin
        x = jitter(trk_x[j], 5000);
        y = jitter(trk_y[j], 5000);
      end
      default: begin
        x = $urandom;
        y = $urandom;
      end
    endcase
    if (n >= 2 && $urandom_range(0, 1) == 1)
      frac = 16'((j * 65536) / n + int'($urandom_range(0, 4000)) - 2000);
    else
      frac = 16'($urandom);
    case ($urandom_range(0, 9))
      0:       start = -int'($urandom_range(1, 1024));
      1:       start = $urandom_range(0, 1023);
      2, 3:    start = j;
      default: start = (n < 2) ? 0 : $urandom_range(0, n - 1);
    endcase
    query(start, x, y, frac);
  endtask

  // wait until every result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input int n, input logic [31:0] thr, input logic [15:0] win);
    drain();
    write_reg(CFG_POINT_COUNT, 32'(n));
    write_reg(CFG_CLOSE_THRESHOLD, thr);
    write_reg(CFG_WINDOW_FRACTION, 32'(win));
  endtask

  initial begin
    int          sent;
    int          n;
    int          m;
    int          k;
    int          idx;
    int          hi;
    bit          first;
    logic [31:0] thr;
    logic [15:0] win;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    squeeze    = 1'b0;
    burst_left = 0;
    cur_x      = $urandom;
    cur_y      = $urandom;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, ignored loads, extreme points
    query(0, 32'h7FFFFFFF, 32'h80000000, 16'h0000);
    load_point(-1, 32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF);
    load_point(-1024, 32'h12345678, 32'h87654321, 31'h1);
    load_point(0, 32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF);
    load_point(1, 32'h80000000, 32'h7FFFFFFF, 31'h0);
    load_point(1023, $urandom, $urandom, TIME_W'($urandom));

    // single point: never found
    set_regs(1, CLOSE_THRESHOLD_RST, WINDOW_FRACTION_RST);
    query(0, 32'h0, 32'h0, 16'h0000);

    // two points: clamped start, start past the count, window misses, widest distances
    set_regs(2, CLOSE_THRESHOLD_RST, WINDOW_FRACTION_RST);
    query(-1, 32'h80000000, 32'h7FFFFFFF, 16'h0000);
    query(1023, 32'h0, 32'h0, 16'hFFFF);
    query(0, 32'h80000000, 32'h7FFFFFFF, 16'h8000);
    set_regs(2, CLOSE_THRESHOLD_RST, 16'hFFFF);
    query(1, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF);
    set_regs(2, CLOSE_THRESHOLD_RST, 16'h0000);
    query(0, 32'h0, 32'h0, 16'h4000);

    // short track: early stop from a start point in the middle
    set_regs(2, 32'hFFFFFFFF, WINDOW_FRACTION_RST);
    for (k = 2; k < 8; k++) put_path_point(k);
    set_regs(8, CLOSE_THRESHOLD_RST, 16'hFFFF);
    query(5, trk_x[6], trk_y[6], 16'hC000);
    query(-1024, trk_x[0], trk_y[0], 16'h0000);
    set_regs(8, 32'h0, 16'h8000);
    query(3, $urandom, $urandom, 16'($urandom));

    // random phases with fresh register settings
    sent = 0;
    first = 1;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       n = $urandom_range(0, 1);
        1:       n = $urandom_range(100, 200);
        default: n = $urandom_range(2, 40);
      endcase
      case ($urandom_range(0, 5))
        0:       thr = 32'h0;
        1:       thr = 32'hFFFFFFFF;
        2:       thr = CLOSE_THRESHOLD_RST;
        3:       thr = $urandom;
        default: thr = $urandom_range(0, 2000000);
      endcase
      case ($urandom_range(0, 5))
        0:       win = 16'h0000;
        1:       win = 16'hFFFF;
        2:       win = WINDOW_FRACTION_RST;
        default: win = 16'($urandom);
      endcase
      for (k = 0; k < n; k++) begin
        if (!written[k]) begin
          put_path_point(k);
          sent++;
        end
      end
      set_regs(n, thr, win);
      m = $urandom_range(10, 40);
      if (first) begin
        // result side holds off while items keep coming
        squeeze <= 1'b1;
        m = 40;
        first = 0;
      end
      for (k = 0; k < m; k++) begin
        if ($urandom_range(0, 9) < 7) begin
          random_query(n);
          sent++;
        end else begin
          hi = (n + 8 > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : n + 8;
          idx = ($urandom_range(0, 7) == 0) ? -int'($urandom_range(1, 1024))
                                            : int'($urandom_range(0, hi));
          put_path_point(idx);
          if (idx >= 0) sent++;
        end
      end
    end

    // full store: largest count, then a count past the store depth
    for (k = 0; k < STORE_DEPTH; k++) begin
      if (!written[k]) put_path_point(k);
    end
    set_regs(STORE_DEPTH, $urandom, 16'($urandom));
    repeat (3) random_query(STORE_DEPTH);
    set_regs(2047, 32'h0, 16'hFFFF);
    repeat (2) random_query(STORE_DEPTH);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_due == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
